// ----- hdl/stb_pkg.sv -----
package stb_pkg;

    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_INIT    = 3'd1;
    localparam logic [2:0] CMD_START   = 3'd2;
    localparam logic [2:0] CMD_STOP    = 3'd3;
    localparam logic [2:0] CMD_DESTROY = 3'd4;
    localparam logic [2:0] CMD_INFO    = 3'd5;

    localparam logic [1:0] ST_CREATED   = 2'd0;
    localparam logic [1:0] ST_STARTED   = 2'd1;
    localparam logic [1:0] ST_STOPPED   = 2'd2;
    localparam logic [1:0] ST_DESTROYED = 2'd3;

    typedef struct packed {
        logic [1:0]  status;
        logic        hard;
        logic [31:0] delay;
        logic [31:0] period;
        logic [31:0] count;
    } t_entry;

    localparam t_entry RESET_ENTRY = '{
        status: ST_DESTROYED,
        hard:   1'b0,
        delay:  32'd0,
        period: 32'd0,
        count:  32'd0
    };

    typedef struct packed {
        logic [7:0]  hard_mask;
        logic [7:0]  soft_mask;
        logic        ok;
        logic [1:0]  state;
        logic [31:0] delay;
        logic [31:0] period;
        logic        info_hard;
    } t_result;

    function automatic logic [31:0] first_load(input logic [31:0] delay,
                                               input logic [31:0] period);
        first_load = (delay != 32'd0) ? delay : period;
    endfunction

endpackage

// ----- hdl/stb_mem.sv -----
module stb_mem #(
    parameter int NUM_TIMERS = 8,
    parameter int IW         = 3
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [IW-1:0]   i_rd_addr,
    output stb_pkg::t_entry o_rd_entry,
    input  logic            i_wr_en,
    input  logic [IW-1:0]   i_wr_addr,
    input  stb_pkg::t_entry i_wr_entry
);

    stb_pkg::t_entry        r_mem [NUM_TIMERS];
    stb_pkg::t_entry        r_rdata;
    logic                   r_rd_valid;
    logic [NUM_TIMERS-1:0]  r_ent_valid;

    // entry storage and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_entry;
        end
        r_rdata <= r_mem[i_rd_addr];
    end

    // per-entry written flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_valid <= '0;
            r_rd_valid  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_ent_valid[i_wr_addr] <= 1'b1;
            end
            r_rd_valid <= r_ent_valid[i_rd_addr];
        end
    end

    assign o_rd_entry = r_rd_valid ? r_rdata : stb_pkg::RESET_ENTRY;

endmodule

// ----- hdl/stb_engine.sv -----
module stb_engine #(
    parameter int NUM_TIMERS = 8,
    parameter int IW         = 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [2:0]       i_command,
    input  logic [2:0]       i_timer_index,
    input  logic [31:0]      i_start_delay,
    input  logic [31:0]      i_period,
    input  logic             i_hard_class,
    output logic [IW-1:0]    o_rd_addr,
    input  stb_pkg::t_entry  i_rd_entry,
    output logic             o_wr_en,
    output logic [IW-1:0]    o_wr_addr,
    output stb_pkg::t_entry  o_wr_entry,
    output logic             o_res_valid,
    output stb_pkg::t_result o_res,
    input  logic            i_res_take
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    localparam logic [IW-1:0] LAST_PTR = IW'(NUM_TIMERS - 1);

    logic [1:0]       r_state, n_state;
    logic [2:0]       r_cmd;
    logic [2:0]       r_idx;
    logic             r_idx_ok;
    logic [31:0]      r_dly;
    logic [31:0]      r_per;
    logic             r_hc;
    logic [IW-1:0]    r_ptr, n_ptr;
    logic [7:0]       r_hard, n_hard;
    logic [7:0]       r_soft, n_soft;
    stb_pkg::t_result r_res, n_res;

    logic             accept;
    logic             in_idx_ok;
    logic             fire;
    logic [31:0]      dec_count;
    stb_pkg::t_entry  ent;
    stb_pkg::t_entry  n_entry;

    assign accept    = i_valid && !o_stall;
    assign in_idx_ok = {29'd0, i_timer_index} < NUM_TIMERS;
    assign o_stall   = (r_state != S_IDLE);
    assign ent       = i_rd_entry;
    assign dec_count = ent.count - 32'd1;

    always_comb begin
        n_state    = r_state;
        n_ptr      = r_ptr;
        n_hard     = r_hard;
        n_soft     = r_soft;
        n_res      = r_res;
        n_entry    = ent;
        o_wr_en    = 1'b0;
        o_wr_addr  = r_idx_ok ? IW'(r_idx) : '0;
        o_rd_addr  = '0;
        fire       = 1'b0;
        o_res_valid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_command != stb_pkg::CMD_TICK && in_idx_ok) begin
                    o_rd_addr = IW'(i_timer_index);
                end
                if (accept) begin
                    n_state = S_EXEC;
                    n_ptr   = '0;
                    n_hard  = '0;
                    n_soft  = '0;
                end
            end
            S_EXEC: begin
                n_res = '0;
                n_res.ok = 1'b1;
                if (r_cmd == stb_pkg::CMD_TICK) begin
                    o_wr_addr = r_ptr;
                    if (ent.status == stb_pkg::ST_STARTED) begin
                        o_wr_en = 1'b1;
                        if (ent.count == 32'd0) begin
                            fire = 1'b1;
                        end else begin
                            n_entry.count = dec_count;
                            fire = (dec_count == 32'd0);
                        end
                        if (fire) begin
                            if (ent.period != 32'd0) begin
                                n_entry.count = ent.period;
                            end else begin
                                n_entry.status = stb_pkg::ST_STOPPED;
                            end
                            if (ent.hard) begin
                                n_hard = r_hard | (8'd1 << r_ptr);
                            end else begin
                                n_soft = r_soft | (8'd1 << r_ptr);
                            end
                        end
                    end
                    if (r_ptr == LAST_PTR) begin
                        n_res.hard_mask = n_hard;
                        n_res.soft_mask = n_soft;
                        n_state = S_DONE;
                    end else begin
                        n_ptr     = r_ptr + 1'b1;
                        o_rd_addr = n_ptr;
                    end
                end else begin
                    n_state = S_DONE;
                    if (r_cmd > stb_pkg::CMD_INFO) begin
                        n_res.ok = 1'b0;
                    end else if (!r_idx_ok) begin
                        n_res.ok = 1'b0;
                        if (r_cmd == stb_pkg::CMD_INFO) begin
                            n_res.state = stb_pkg::ST_DESTROYED;
                        end
                    end else begin
                        unique case (r_cmd)
                            stb_pkg::CMD_INIT: begin
                                o_wr_en        = 1'b1;
                                n_entry.status = stb_pkg::ST_CREATED;
                                n_entry.hard   = r_hc;
                                n_entry.delay  = r_dly;
                                n_entry.period = r_per;
                                n_entry.count  = stb_pkg::first_load(r_dly, r_per);
                            end
                            stb_pkg::CMD_START: begin
                                if (ent.status == stb_pkg::ST_CREATED ||
                                    ent.status == stb_pkg::ST_STOPPED) begin
                                    o_wr_en        = 1'b1;
                                    n_entry.status = stb_pkg::ST_STARTED;
                                    n_entry.count  =
                                        stb_pkg::first_load(ent.delay, ent.period);
                                end else begin
                                    n_res.ok = 1'b0;
                                end
                            end
                            stb_pkg::CMD_STOP: begin
                                if (ent.status == stb_pkg::ST_STARTED) begin
                                    o_wr_en        = 1'b1;
                                    n_entry.status = stb_pkg::ST_STOPPED;
                                end else begin
                                    n_res.ok = 1'b0;
                                end
                            end
                            stb_pkg::CMD_DESTROY: begin
                                o_wr_en        = 1'b1;
                                n_entry.status = stb_pkg::ST_DESTROYED;
                            end
                            stb_pkg::CMD_INFO: begin
                                n_res.state     = ent.status;
                                n_res.delay     = ent.delay;
                                n_res.period    = ent.period;
                                n_res.info_hard = ent.hard;
                            end
                            default: begin
                                n_res.ok = 1'b0;
                            end
                        endcase
                    end
                end
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_wr_entry = n_entry;
    assign o_res      = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd    <= i_command;
            r_idx    <= i_timer_index;
            r_idx_ok <= in_idx_ok;
            r_dly    <= i_start_delay;
            r_per    <= i_period;
            r_hc     <= i_hard_class;
        end
        r_ptr  <= n_ptr;
        r_hard <= n_hard;
        r_soft <= n_soft;
        r_res  <= n_res;
    end

endmodule

// ----- hdl/software_timer_bank.sv -----
// a tick walks the entry memory one entry per cycle, then its result word is
// registered and passed to the output register; other commands work on a single
// entry. A new command is taken only once the last result has moved into the
// output register, so commands never overlap
// reset: synchronous active-low i_rst_n; all timers read as destroyed with zero
// values, output word empty; no clearing pass
module software_timer_bank #(
    parameter int NUM_TIMERS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_command,
    input  logic [2:0]  i_timer_index,
    input  logic [31:0] i_start_delay,
    input  logic [31:0] i_period,
    input  logic        i_hard_class,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_expired_hard_mask,
    output logic [7:0]  o_expired_soft_mask,
    output logic        o_command_ok,
    output logic [1:0]  o_info_state,
    output logic [31:0] o_info_start_delay,
    output logic [31:0] o_info_period,
    output logic        o_info_hard
);

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    logic             rd_valid_unused;
    logic [IW-1:0]    rd_addr;
    stb_pkg::t_entry  rd_entry;
    logic             wr_en;
    logic [IW-1:0]    wr_addr;
    stb_pkg::t_entry  wr_entry;
    logic             res_valid;
    logic             res_take;
    stb_pkg::t_result res;
    stb_pkg::t_result r_out;
    logic             r_out_valid;

    assign rd_valid_unused = 1'b0;

    stb_mem #(
        .NUM_TIMERS (NUM_TIMERS),
        .IW         (IW)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_addr  (rd_addr),
        .o_rd_entry (rd_entry),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_entry (wr_entry)
    );

    stb_engine #(
        .NUM_TIMERS (NUM_TIMERS),
        .IW         (IW)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_timer_index (i_timer_index),
        .i_start_delay (i_start_delay),
        .i_period      (i_period),
        .i_hard_class  (i_hard_class),
        .o_rd_addr     (rd_addr),
        .i_rd_entry    (rd_entry),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_entry    (wr_entry),
        .o_res_valid   (res_valid),
        .o_res         (res),
        .i_res_take    (res_take)
    );

    // output word register
    assign res_take = res_valid && (!r_out_valid || !i_stall) && !rd_valid_unused;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_expired_hard_mask = r_out.hard_mask;
    assign o_expired_soft_mask = r_out.soft_mask;
    assign o_command_ok        = r_out.ok;
    assign o_info_state        = r_out.state;
    assign o_info_start_delay  = r_out.delay;
    assign o_info_period       = r_out.period;
    assign o_info_hard         = r_out.info_hard;

endmodule

// ----- hdl/stb_checker.sv -----
module stb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [7:0]  o_expired_hard_mask,
    input logic [7:0]  o_expired_soft_mask,
    input logic        o_command_ok,
    input logic [1:0]  o_info_state,
    input logic [31:0] o_info_period
);

    // a timer has one class, so it never shows in both masks
    a_masks_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_expired_hard_mask & o_expired_soft_mask) == 8'd0))
        else $error("timer reported in both masks");

    // a word with expirations is a tick word: ok set, info fields clear
    a_tick_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_expired_hard_mask != 8'd0 || o_expired_soft_mask != 8'd0))
        |-> (o_command_ok && o_info_state == 2'd0 && o_info_period == 32'd0))
        else $error("expiration word carries non-tick fields");

    // a taken word keeps the input side busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken again without processing");

    // the output holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("output word dropped under stall");

endmodule

bind software_timer_bank stb_checker u_stb_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_valid             (i_valid),
    .o_stall             (o_stall),
    .o_valid             (o_valid),
    .i_stall             (i_stall),
    .o_expired_hard_mask (o_expired_hard_mask),
    .o_expired_soft_mask (o_expired_soft_mask),
    .o_command_ok        (o_command_ok),
    .o_info_state        (o_info_state),
    .o_info_period       (o_info_period)
);
